### hw/rtl/bitmap_page_allocator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap page allocator
// Clocked property wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define BPA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("bpa assertion failed");

// next-cycle implication, ignored while in reset
`define BPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("bpa assertion failed");

// next-cycle implication that is also checked across reset
`define BPA_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("bpa reset assertion failed");

`endif

### hw/rtl/bpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, codes, types and bit search helpers of the page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int MEM_SIZE_W = 29;
    localparam int RES_END_W  = 28;
    localparam int CFG_W      = 29;
    localparam int ADDR_W     = 32;
    localparam int OP_W       = 2;
    localparam int PA_W       = 28;
    localparam int STS_W      = 2;
    localparam int CNT_OUT_W  = 17;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 48;
    localparam int M_PAD_W    = M_TDATA_W - PA_W - CNT_OUT_W;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

    localparam logic [STS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STS_W-1:0] STS_NO_FREE  = 2'd1;
    localparam logic [STS_W-1:0] STS_NOT_USED = 2'd2;
    localparam logic [STS_W-1:0] STS_RANGE    = 2'd3;

    localparam logic REG_MEM_SIZE = 1'b0;
    localparam logic REG_RES_END  = 1'b1;

    typedef struct packed {
        logic       found;
        logic [4:0] idx;
    } bit_hit_t;

    typedef struct packed {
        logic map_we;
        logic sum_we;
        logic done;
    } sweep_ctl_t;

    function automatic bit_hit_t lowest_one(input logic [31:0] w);
        bit_hit_t r;
        r.found = 1'b0;
        r.idx   = 5'd0;
        for (int i = 31; i >= 0; i--) begin
            if (w[i]) begin
                r.found = 1'b1;
                r.idx   = 5'(i);
            end
        end
        return r;
    endfunction

    function automatic bit_hit_t lowest_zero(input logic [31:0] w);
        return lowest_one(~w);
    endfunction

endpackage

### hw/rtl/bpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/bpa_sweep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_sweep
// Rewrites the whole page map, one word a cycle, and builds the summary of
// non-full words alongside. Runs after reset and for each init request.
// ----------------------------------------------------------------------------
module bpa_sweep #(
    parameter int MAP_WORDS = 2048,
    parameter int FIRST_W   = 17,
    parameter int TOT_W     = 17
) (
    input  logic                                                   aclk,
    input  logic                                                   aresetn,
    input  logic                                                   start,
    input  logic [FIRST_W-1:0]                                     first,
    input  logic [TOT_W-1:0]                                       total,
    output bpa_pkg::sweep_ctl_t                                    ctl,
    output logic [(MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1)-1:0]     map_addr,
    output logic [31:0]                                            map_data,
    output logic [((MAP_WORDS + 31) / 32 > 1 ?
                   $clog2((MAP_WORDS + 31) / 32) : 1)-1:0]         sum_addr,
    output logic [31:0]                                            sum_data
);

    localparam int WW        = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
    localparam int SUM_DEPTH = (MAP_WORDS + 31) / 32;
    localparam int SWW       = SUM_DEPTH > 1 ? $clog2(SUM_DEPTH) : 1;
    localparam int NUM_W     = FIRST_W > TOT_W ? FIRST_W : TOT_W;

    logic          active_reg, active_next;
    logic [WW-1:0] widx_reg, widx_next;
    logic [31:0]   acc_reg, acc_next;

    logic [31:0]    wval;
    logic [31:0]    acc_now;
    logic [4:0]     lane;
    logic           last;
    logic           grp_end;

    always_comb begin
        logic [NUM_W-1:0] base;
        logic [NUM_W-1:0] p;
        base = NUM_W'(widx_reg) << 5;
        for (int b = 0; b < 32; b++) begin
            p       = base + NUM_W'(b);
            wval[b] = !((p >= NUM_W'(first)) && (p < NUM_W'(total)));
        end
    end

    assign lane    = 5'(widx_reg);
    assign last    = (widx_reg == WW'(MAP_WORDS - 1));
    assign grp_end = (lane == 5'd31) || last;
    assign acc_now = acc_reg | (32'(wval != 32'hFFFF_FFFF) << lane);

    assign ctl.map_we = active_reg;
    assign ctl.sum_we = active_reg && grp_end;
    assign ctl.done   = active_reg && last;
    assign map_addr   = widx_reg;
    assign map_data   = wval;
    assign sum_addr   = SWW'(widx_reg >> 5);
    assign sum_data   = acc_now;

    always_comb begin
        active_next = active_reg;
        widx_next   = widx_reg;
        acc_next    = acc_reg;
        if (start) begin
            active_next = 1'b1;
            widx_next   = '0;
            acc_next    = '0;
        end else if (active_reg) begin
            active_next = !last;
            widx_next   = last ? '0 : WW'(widx_reg + 1'b1);
            acc_next    = grp_end ? '0 : acc_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b1;
            widx_reg   <= '0;
            acc_reg    <= '0;
        end else begin
            active_reg <= active_next;
            widx_reg   <= widx_next;
            acc_reg    <= acc_next;
        end
    end

endmodule

### hw/rtl/bitmap_page_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator_unit
// First-fit physical page allocator over a one-bit-per-page map in RAM,
// with a summary RAM holding one non-full flag per map word.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_*       in         tuser: operation, tdata: address
//  m_*       out        tuser: status, tdata: page_address, pages_in_use
//  cfg_*     in         register writes (memory_size, reserved_end)
//
//  Alloc: straight to the result with no pages, else the summary words are
//  scanned in order (MAP_WORDS/32 words max), then the map word is read.
//  Free: reads the map word, then its summary word if the page was in use.
//  Init sweeps the map one word per cycle, as after reset (s_tready low).
//  One request at a time; the result register lets the next request in
//  while m_tready is low, but a second result waits for the first.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_unit #(
    parameter int MAP_WORDS  = 2048,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [bpa_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bpa_pkg::S_TDATA_W-1:0]   s_tdata,   // [31:0] address
    input  logic [bpa_pkg::OP_W-1:0]        s_tuser,   // [1:0] operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bpa_pkg::M_TDATA_W-1:0]   m_tdata,   // [27:0] page_address,
                                                       // [44:28] pages_in_use
    output logic [bpa_pkg::STS_W-1:0]       m_tuser    // [1:0] status
);

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PAGE_CAP   = MAP_WORDS * 32;
    localparam int PW         = $clog2(PAGE_CAP);
    localparam int TOT_W      = PW + 1;
    localparam int FIRST_W    = bpa_pkg::MEM_SIZE_W - PAGE_SHIFT;
    localparam int NUM_W      = FIRST_W > TOT_W ? FIRST_W : TOT_W;
    localparam int CNT_W      = bpa_pkg::CNT_OUT_W > TOT_W ? bpa_pkg::CNT_OUT_W : TOT_W;
    localparam int WW         = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
    localparam int SUM_DEPTH  = (MAP_WORDS + 31) / 32;
    localparam int SWW        = SUM_DEPTH > 1 ? $clog2(SUM_DEPTH) : 1;
    localparam int FP_W       = bpa_pkg::ADDR_W - PAGE_SHIFT;
    localparam int TRAW_W     = bpa_pkg::MEM_SIZE_W - PAGE_SHIFT;

    localparam logic [2:0] FSM_SWEEP = 3'd0;
    localparam logic [2:0] FSM_IDLE  = 3'd1;
    localparam logic [2:0] FSM_SCAN  = 3'd2;
    localparam logic [2:0] FSM_AREAD = 3'd3;
    localparam logic [2:0] FSM_FREAD = 3'd4;
    localparam logic [2:0] FSM_FSUM  = 3'd5;
    localparam logic [2:0] FSM_RESP  = 3'd6;

    logic [2:0]                          state_reg, state_next;
    logic [SWW-1:0]                      sidx_reg, sidx_next;
    logic [WW-1:0]                       widx_reg, widx_next;
    logic [TOT_W-1:0]                    page_total_reg, page_total_next;
    logic [FIRST_W-1:0]                  first_reg, first_next;
    logic [CNT_W-1:0]                    cnt_reg, cnt_next;
    logic [bpa_pkg::MEM_SIZE_W-1:0]      mem_size_reg;
    logic [bpa_pkg::RES_END_W-1:0]       res_end_reg;
    logic                                sweep_resp_reg, sweep_resp_next;
    logic [bpa_pkg::PA_W-1:0]            res_pa_reg, res_pa_next;
    logic [bpa_pkg::STS_W-1:0]           res_st_reg, res_st_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [bpa_pkg::PA_W-1:0]            m_pa_reg;
    logic [bpa_pkg::STS_W-1:0]           m_st_reg;
    logic [bpa_pkg::CNT_OUT_W-1:0]       m_cnt_reg;

    logic                 accept;
    logic                 load_out;
    logic                 sweep_start;
    bpa_pkg::sweep_ctl_t  sw_ctl;
    logic [WW-1:0]        sw_map_addr;
    logic [31:0]          sw_map_data;
    logic [SWW-1:0]       sw_sum_addr;
    logic [31:0]          sw_sum_data;

    logic                 map_we, map_re, f_map_we, f_map_re;
    logic [WW-1:0]        map_addr, f_map_addr;
    logic [31:0]          map_wdata, f_map_wdata, map_q;
    logic                 sum_we, sum_re, f_sum_we, f_sum_re;
    logic [SWW-1:0]       sum_addr, f_sum_addr;
    logic [31:0]          sum_wdata, f_sum_wdata, sum_q;

    logic [FP_W-1:0]      fpage;
    logic [TRAW_W-1:0]    total_raw;
    logic [TOT_W-1:0]     total_calc;
    logic [FIRST_W-1:0]   first_calc;
    bpa_pkg::bit_hit_t    sum_hit;
    bpa_pkg::bit_hit_t    map_hit;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == FSM_IDLE);
    assign load_out = (state_reg == FSM_RESP) && (!m_tvalid_reg || m_tready);

    assign fpage      = FP_W'(s_tdata >> PAGE_SHIFT);
    assign total_raw  = TRAW_W'(mem_size_reg >> PAGE_SHIFT);
    assign total_calc = (32'(total_raw) > 32'(PAGE_CAP)) ? TOT_W'(PAGE_CAP)
                                                          : TOT_W'(total_raw);
    assign first_calc = FIRST_W'((bpa_pkg::MEM_SIZE_W'(res_end_reg)
                                  + bpa_pkg::MEM_SIZE_W'(PAGE_BYTES - 1)) >> PAGE_SHIFT);
    assign sum_hit    = bpa_pkg::lowest_one(sum_q);
    assign map_hit    = bpa_pkg::lowest_zero(map_q);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_size_reg <= '0;
            res_end_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                bpa_pkg::REG_MEM_SIZE: mem_size_reg <= cfg_data;
                bpa_pkg::REG_RES_END:  res_end_reg  <= bpa_pkg::RES_END_W'(cfg_data);
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [31:0] page;
        logic [31:0] newword;
        logic [WW-1:0] w;

        state_next      = state_reg;
        sidx_next       = sidx_reg;
        widx_next       = widx_reg;
        page_total_next = page_total_reg;
        first_next      = first_reg;
        cnt_next        = cnt_reg;
        sweep_resp_next = sweep_resp_reg;
        res_pa_next     = res_pa_reg;
        res_st_next     = res_st_reg;
        sweep_start     = 1'b0;
        f_map_we        = 1'b0;
        f_map_re        = 1'b0;
        f_map_addr      = widx_reg;
        f_map_wdata     = map_q;
        f_sum_we        = 1'b0;
        f_sum_re        = 1'b0;
        f_sum_addr      = sidx_reg;
        f_sum_wdata     = sum_q;
        page            = (32'(widx_reg) << 5) | 32'(map_hit.idx);
        newword         = map_q | (32'd1 << map_hit.idx);
        w               = WW'((32'(sidx_reg) << 5) | 32'(sum_hit.idx));

        case (state_reg)
            FSM_SWEEP: begin
                if (sw_ctl.done) begin
                    if (sweep_resp_reg) begin
                        res_pa_next = '0;
                        res_st_next = bpa_pkg::STS_OK;
                        state_next  = FSM_RESP;
                    end else begin
                        state_next  = FSM_IDLE;
                    end
                    sweep_resp_next = 1'b0;
                end
            end
            FSM_IDLE: begin
                if (accept) begin
                    res_pa_next = '0;
                    res_st_next = bpa_pkg::STS_OK;
                    case (s_tuser)
                        bpa_pkg::OP_ALLOC: begin
                            if (page_total_reg == '0) begin
                                res_st_next = bpa_pkg::STS_NO_FREE;
                                state_next  = FSM_RESP;
                            end else begin
                                f_sum_re   = 1'b1;
                                f_sum_addr = '0;
                                sidx_next  = '0;
                                state_next = FSM_SCAN;
                            end
                        end
                        bpa_pkg::OP_FREE: begin
                            if (32'(fpage) >= 32'(PAGE_CAP)) begin
                                res_st_next = bpa_pkg::STS_RANGE;
                                state_next  = FSM_RESP;
                            end else begin
                                widx_next  = WW'(fpage >> 5);
                                f_map_re   = 1'b1;
                                f_map_addr = WW'(fpage >> 5);
                                state_next = FSM_FREAD;
                            end
                        end
                        bpa_pkg::OP_INIT: begin
                            page_total_next = total_calc;
                            first_next      = first_calc;
                            cnt_next        = (NUM_W'(first_calc) < NUM_W'(total_calc))
                                              ? CNT_W'(first_calc) : CNT_W'(total_calc);
                            sweep_start     = 1'b1;
                            sweep_resp_next = 1'b1;
                            state_next      = FSM_SWEEP;
                        end
                        default: begin
                            state_next = FSM_RESP;
                        end
                    endcase
                end
            end
            FSM_SCAN: begin
                if (sum_hit.found) begin
                    if ((32'(w) << 5) < 32'(page_total_reg)) begin
                        widx_next  = w;
                        f_map_re   = 1'b1;
                        f_map_addr = w;
                        state_next = FSM_AREAD;
                    end else begin
                        res_st_next = bpa_pkg::STS_NO_FREE;
                        state_next  = FSM_RESP;
                    end
                end else if ((sidx_reg == SWW'(SUM_DEPTH - 1))
                          || (((32'(sidx_reg) + 32'd1) << 10) >= 32'(page_total_reg))) begin
                    res_st_next = bpa_pkg::STS_NO_FREE;
                    state_next  = FSM_RESP;
                end else begin
                    sidx_next  = SWW'(sidx_reg + 1'b1);
                    f_sum_re   = 1'b1;
                    f_sum_addr = SWW'(sidx_reg + 1'b1);
                end
            end
            FSM_AREAD: begin
                if (map_hit.found && (page < 32'(page_total_reg))) begin
                    f_map_we    = 1'b1;
                    f_map_wdata = newword;
                    f_sum_we    = 1'b1;
                    f_sum_addr  = sidx_reg;
                    f_sum_wdata = (newword == 32'hFFFF_FFFF)
                                  ? (sum_q & ~(32'd1 << 5'(widx_reg))) : sum_q;
                    cnt_next    = CNT_W'(bpa_pkg::CNT_OUT_W'(cnt_reg + 1'b1));
                    res_pa_next = bpa_pkg::PA_W'(page << PAGE_SHIFT);
                end else begin
                    res_st_next = bpa_pkg::STS_NO_FREE;
                end
                state_next = FSM_RESP;
            end
            FSM_FREAD: begin
                if (!map_q[res_pa_reg[4:0]]) begin
                    res_st_next = bpa_pkg::STS_NOT_USED;
                    state_next  = FSM_RESP;
                end else begin
                    f_map_we    = 1'b1;
                    f_map_wdata = map_q & ~(32'd1 << res_pa_reg[4:0]);
                    f_sum_re    = 1'b1;
                    f_sum_addr  = SWW'(widx_reg >> 5);
                    state_next  = FSM_FSUM;
                end
            end
            FSM_FSUM: begin
                f_sum_we    = 1'b1;
                f_sum_addr  = SWW'(widx_reg >> 5);
                f_sum_wdata = sum_q | (32'd1 << 5'(widx_reg));
                if (cnt_reg != '0) begin
                    cnt_next = CNT_W'(cnt_reg - 1'b1);
                end
                res_pa_next = '0;
                state_next  = FSM_RESP;
            end
            FSM_RESP: begin
                if (load_out) begin
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase

        // free keeps the bit lane of the page in res_pa until the result is formed
        if (state_reg == FSM_IDLE && accept && s_tuser == bpa_pkg::OP_FREE
            && 32'(fpage) < 32'(PAGE_CAP)) begin
            res_pa_next = bpa_pkg::PA_W'(fpage[4:0]);
        end
        if (state_reg == FSM_FREAD && !map_q[res_pa_reg[4:0]]) begin
            res_pa_next = '0;
        end
    end

    always_comb begin
        if (state_reg == FSM_SWEEP) begin
            map_we    = sw_ctl.map_we;
            map_re    = 1'b0;
            map_addr  = sw_map_addr;
            map_wdata = sw_map_data;
            sum_we    = sw_ctl.sum_we;
            sum_re    = 1'b0;
            sum_addr  = sw_sum_addr;
            sum_wdata = sw_sum_data;
        end else begin
            map_we    = f_map_we;
            map_re    = f_map_re;
            map_addr  = f_map_addr;
            map_wdata = f_map_wdata;
            sum_we    = f_sum_we;
            sum_re    = f_sum_re;
            sum_addr  = f_sum_addr;
            sum_wdata = f_sum_wdata;
        end
    end

    assign m_tvalid_next = (m_tvalid_reg && !m_tready) || load_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= FSM_SWEEP;
            sidx_reg       <= '0;
            widx_reg       <= '0;
            page_total_reg <= '0;
            first_reg      <= '0;
            cnt_reg        <= '0;
            sweep_resp_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sidx_reg       <= sidx_next;
            widx_reg       <= widx_next;
            page_total_reg <= page_total_next;
            first_reg      <= first_next;
            cnt_reg        <= cnt_next;
            sweep_resp_reg <= sweep_resp_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_pa_reg <= res_pa_next;
        res_st_reg <= res_st_next;
        if (load_out) begin
            m_pa_reg  <= res_pa_reg;
            m_st_reg  <= res_st_reg;
            m_cnt_reg <= bpa_pkg::CNT_OUT_W'(cnt_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{bpa_pkg::M_PAD_W{1'b0}}, m_cnt_reg, m_pa_reg};
    assign m_tuser  = m_st_reg;

    bpa_sweep #(
        .MAP_WORDS (MAP_WORDS),
        .FIRST_W   (FIRST_W),
        .TOT_W     (TOT_W)
    ) u_sweep (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sweep_start),
        .first    (first_next),
        .total    (page_total_reg),
        .ctl      (sw_ctl),
        .map_addr (sw_map_addr),
        .map_data (sw_map_data),
        .sum_addr (sw_sum_addr),
        .sum_data (sw_sum_data)
    );

    bpa_ram #(
        .WIDTH (32),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .aclk  (aclk),
        .we    (map_we),
        .re    (map_re),
        .addr  (map_addr),
        .wdata (map_wdata),
        .rdata (map_q)
    );

    bpa_ram #(
        .WIDTH (32),
        .DEPTH (SUM_DEPTH)
    ) u_sum (
        .aclk  (aclk),
        .we    (sum_we),
        .re    (sum_re),
        .addr  (sum_addr),
        .wdata (sum_wdata),
        .rdata (sum_q)
    );

endmodule

### hw/rtl/bpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks of the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitmap_page_allocator_unit_assert.svh"

module bpa_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bpa_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [bpa_pkg::STS_W-1:0]       m_tuser
);

    `BPA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    `BPA_ASSERT_SAME(a_fail_no_addr, m_tvalid && (m_tuser != bpa_pkg::STS_OK),
                     m_tdata[bpa_pkg::PA_W-1:0] == '0)

    `BPA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)

    `BPA_ASSERT_RST(a_reset_sweep, !aresetn, !s_tready && !m_tvalid)

endmodule

bind bitmap_page_allocator_unit bpa_checker u_bpa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
